// ----- rtl/core/ethernet_frame_classifier_assert.svh -----
// assertion macros for the ethernet frame classifier checker
// no dependencies; included by the checker file only
`ifndef ETHERNET_FRAME_CLASSIFIER_ASSERT_SVH
`define ETHERNET_FRAME_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define EFC_ASSERT_IMPL(lbl, clock, reset, ante, cons, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EFC_ASSERT_NEXT(lbl, clock, reset, ante, cons, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/efc_pkg.sv -----
// shared types, codes and lookup functions of the frame classifier
// no dependencies; used by every module of the block
package efc_pkg;

  localparam int MAX_CAPTURE_DEF = 2048;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] REG_TIME_LEN = 2'd0;
  localparam logic [1:0] REG_COUNT_LEN = 2'd1;
  localparam logic [1:0] REG_CAPTURE_LEN = 2'd2;

  localparam logic [4:0] TIME_LEN_RST = 5'd4;
  localparam logic [4:0] COUNT_LEN_RST = 5'd2;
  localparam logic [10:0] CAPTURE_LEN_RST = 11'd64;

  localparam logic [4:0] CODE_TIME = 5'd0;
  localparam logic [4:0] CODE_SIZE = 5'd1;
  localparam logic [4:0] CODE_ETH_SRC = 5'd2;
  localparam logic [4:0] CODE_ETH_DEST = 5'd3;
  localparam logic [4:0] CODE_ETH_HDR = 5'd4;
  localparam logic [4:0] CODE_ETHERTYPE = 5'd5;
  localparam logic [4:0] CODE_IP = 5'd6;
  localparam logic [4:0] CODE_DDP = 5'd7;
  localparam logic [4:0] CODE_XEROX = 5'd8;
  localparam logic [4:0] CODE_ARP = 5'd9;
  localparam logic [4:0] CODE_MOP = 5'd10;
  localparam logic [4:0] CODE_DECNET = 5'd11;
  localparam logic [4:0] CODE_LAT = 5'd12;
  localparam logic [4:0] CODE_LAVC = 5'd13;
  localparam logic [4:0] CODE_BRIDGE = 5'd14;
  localparam logic [4:0] CODE_UNKNOWN_NET = 5'd15;
  localparam logic [4:0] CODE_LLC_HDR = 5'd16;
  localparam logic [4:0] CODE_LLC_SRC = 5'd17;
  localparam logic [4:0] CODE_LLC_DEST = 5'd18;
  localparam logic [4:0] CODE_SNAP = 5'd19;
  localparam logic [4:0] CODE_SNAP_ORG = 5'd20;
  localparam logic [4:0] CODE_DSAP = 5'd21;
  localparam logic [4:0] CODE_LLC_UNKNOWN = 5'd22;

  localparam logic [15:0] MAX_LENGTH_FIELD = 16'd1500;
  localparam logic [15:0] ETYPE_IP = 16'h0800;
  localparam logic [15:0] ETYPE_DDP = 16'h809B;
  localparam logic [15:0] ETYPE_XEROX = 16'h9000;
  localparam logic [15:0] ETYPE_ARP = 16'h0806;
  localparam logic [15:0] ETYPE_AARP = 16'h80F3;
  localparam logic [15:0] ETYPE_MOP = 16'h6002;
  localparam logic [15:0] ETYPE_DECNET = 16'h6003;
  localparam logic [15:0] ETYPE_LAT = 16'h6004;
  localparam logic [15:0] ETYPE_LAVC = 16'h6007;
  localparam logic [15:0] ETYPE_BRIDGE = 16'h8038;
  localparam logic [15:0] LLC_SNAP = 16'hAAAA;
  localparam logic [15:0] LLC_DSAP = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_ETH,
    KIND_SNAP,
    KIND_DSAP,
    KIND_UNKNOWN
  } frame_kind_t;

  typedef enum logic [3:0] {
    STEP_TIME,
    STEP_SIZE,
    STEP_SRC,
    STEP_DEST,
    STEP_HDR,
    STEP_ETYPE,
    STEP_NEST,
    STEP_LLC_HDR,
    STEP_LLC_SRC,
    STEP_LLC_DEST,
    STEP_SNAP,
    STEP_SNAP_ORG,
    STEP_DSAP,
    STEP_LLC_UNK
  } step_t;

  typedef struct packed {
    logic [4:0] time_len;
    logic [4:0] count_len;
    logic [5:0] hdr;
    logic cap_nz;
    frame_kind_t kind;
    logic [11:0] eoff;
    logic nest_valid;
    logic [4:0] nest_code;
    logic [10:0] nest_len;
    logic [10:0] dsap_len;
  } rec_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } queue_ctl_t;

  function automatic logic [4:0] etype_code(input logic [15:0] t);
    logic [4:0] c;
    c = CODE_UNKNOWN_NET;
    if (t == ETYPE_IP) c = CODE_IP;
    else if (t == ETYPE_DDP) c = CODE_DDP;
    else if (t == ETYPE_XEROX) c = CODE_XEROX;
    else if (t == ETYPE_ARP || t == ETYPE_AARP) c = CODE_ARP;
    else if (t == ETYPE_MOP) c = CODE_MOP;
    else if (t == ETYPE_DECNET) c = CODE_DECNET;
    else if (t == ETYPE_LAT) c = CODE_LAT;
    else if (t == ETYPE_LAVC) c = CODE_LAVC;
    else if (t == ETYPE_BRIDGE) c = CODE_BRIDGE;
    return c;
  endfunction

  function automatic logic [10:0] nest_length(input logic [4:0] code, input logic [10:0] rest);
    logic [10:0] l;
    l = rest;
    if (code == CODE_IP && rest > 11'd20) l = 11'd20;
    else if (code == CODE_DDP && rest > 11'd13) l = 11'd13;
    else if (code == CODE_ARP && rest > 11'd28) l = 11'd28;
    return l;
  endfunction

endpackage

// ----- rtl/core/efc_front.sv -----
// front end: config registers, record byte counter, header word capture and classify
// depends on efc_pkg
module efc_front #(
  parameter int MAX_CAPTURE = efc_pkg::MAX_CAPTURE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data,
  input  logic               byte_valid,
  output logic               byte_ready,
  input  logic [7:0]         data_byte,
  input  logic               q_full,
  output logic               q_push,
  output efc_pkg::rec_t      q_data
);

  logic [4:0] time_len;
  logic [4:0] count_len;
  logic [10:0] capture_len;
  logic [11:0] pos;
  logic [15:0] tlw;
  logic [15:0] llc;
  logic [15:0] snap;

  logic [10:0] cap;
  logic [5:0] hdr;
  logic [11:0] reclen;
  logic ends;
  logic take;
  logic [11:0] f;
  logic in_frame;
  logic [15:0] tlw_next;
  logic [15:0] llc_next;
  logic [15:0] snap_next;
  logic is_eth;
  logic is_snap;
  logic [15:0] etype;
  logic [10:0] rest;
  logic [4:0] ncode;

  assign cap = (32'(capture_len) > MAX_CAPTURE) ? 11'(MAX_CAPTURE) : capture_len;
  assign hdr = {1'b0, time_len} + {1'b0, count_len};
  assign reclen = {6'b0, hdr} + {1'b0, cap};
  assign ends = ({1'b0, pos} + 13'd1) >= {1'b0, reclen};
  assign byte_ready = !(ends && q_full);
  assign take = byte_valid && byte_ready;
  assign in_frame = pos >= {6'b0, hdr};
  assign f = pos - {6'b0, hdr};

  always_comb begin
    tlw_next = tlw;
    llc_next = llc;
    snap_next = snap;
    if (in_frame) begin
      case (f)
        12'd12: tlw_next = {data_byte, tlw[7:0]};
        12'd13: tlw_next = {tlw[15:8], data_byte};
        12'd14: llc_next = {data_byte, llc[7:0]};
        12'd15: llc_next = {llc[15:8], data_byte};
        12'd20: snap_next = {data_byte, snap[7:0]};
        12'd21: snap_next = {snap[15:8], data_byte};
        default: ;
      endcase
    end
  end

  assign is_eth = tlw_next > efc_pkg::MAX_LENGTH_FIELD;
  assign is_snap = !is_eth && llc_next == efc_pkg::LLC_SNAP && cap >= 11'd19;
  assign etype = is_eth ? tlw_next : snap_next;
  assign rest = is_eth ? cap - 11'd14 : cap - 11'd22;
  assign ncode = efc_pkg::etype_code(etype);

  always_comb begin
    q_data.time_len = time_len;
    q_data.count_len = count_len;
    q_data.hdr = hdr;
    q_data.cap_nz = cap != 11'd0;
    if (is_eth) q_data.kind = efc_pkg::KIND_ETH;
    else if (is_snap) q_data.kind = efc_pkg::KIND_SNAP;
    else if (llc_next == efc_pkg::LLC_DSAP) q_data.kind = efc_pkg::KIND_DSAP;
    else q_data.kind = efc_pkg::KIND_UNKNOWN;
    q_data.eoff = {6'b0, hdr} + (is_eth ? 12'd12 : 12'd20);
    q_data.nest_valid = is_eth ? (cap >= 11'd14) : (cap >= 11'd22);
    q_data.nest_code = ncode;
    q_data.nest_len = efc_pkg::nest_length(ncode, rest);
    q_data.dsap_len = (cap >= 11'd17) ? cap - 11'd17 : 11'd0;
  end

  assign q_push = take && ends;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_len <= efc_pkg::TIME_LEN_RST;
      count_len <= efc_pkg::COUNT_LEN_RST;
      capture_len <= efc_pkg::CAPTURE_LEN_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        efc_pkg::REG_TIME_LEN: time_len <= cfg_data[4:0];
        efc_pkg::REG_COUNT_LEN: count_len <= cfg_data[4:0];
        efc_pkg::REG_CAPTURE_LEN: capture_len <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      tlw <= '0;
      llc <= '0;
      snap <= '0;
    end else if (take) begin
      if (ends) begin
        pos <= '0;
        tlw <= '0;
        llc <= '0;
        snap <= '0;
      end else begin
        pos <= pos + 12'd1;
        tlw <= tlw_next;
        llc <= llc_next;
        snap <= snap_next;
      end
    end
  end

endmodule

// ----- rtl/core/efc_queue.sv -----
// short record queue between the front and the back end
// depends on efc_pkg
module efc_queue (
  input  logic                clk,
  input  logic                rst,
  input  efc_pkg::queue_ctl_t ctl_in,
  output efc_pkg::queue_ctl_t ctl_out,
  input  efc_pkg::rec_t       wr_data,
  output efc_pkg::rec_t       rd_data
);

  efc_pkg::rec_t entries [efc_pkg::QUEUE_DEPTH];
  logic [efc_pkg::QPTR_W-1:0] wr_ptr;
  logic [efc_pkg::QPTR_W-1:0] rd_ptr;
  logic [efc_pkg::QPTR_W:0] count;
  logic do_push;
  logic do_pop;

  localparam logic [efc_pkg::QPTR_W-1:0] LAST_PTR = efc_pkg::QPTR_W'(efc_pkg::QUEUE_DEPTH - 1);
  localparam logic [efc_pkg::QPTR_W:0] FULL_COUNT = (efc_pkg::QPTR_W + 1)'(efc_pkg::QUEUE_DEPTH);

  assign ctl_out.full = count == FULL_COUNT;
  assign ctl_out.empty = count == '0;
  assign ctl_out.push = do_push;
  assign ctl_out.pop = do_pop;
  assign do_push = ctl_in.push && !ctl_out.full;
  assign do_pop = ctl_in.pop && !ctl_out.empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

// ----- rtl/core/efc_back.sv -----
// back end: walks one queued record through its feature list into an output register
// depends on efc_pkg
module efc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  output logic           q_pop,
  input  efc_pkg::rec_t  q_head,
  output logic           feature_valid,
  input  logic           feature_ready,
  output logic [4:0]     feature_code,
  output logic [11:0]    field_offset,
  output logic [10:0]    field_length,
  output logic           last_feature
);

  efc_pkg::rec_t rec;
  efc_pkg::step_t cur;
  efc_pkg::step_t step_next;
  logic busy;
  logic adv;
  logic load;
  logic [4:0] s_code;
  logic [11:0] s_off;
  logic [10:0] s_len;
  logic s_last;
  logic [11:0] hdr12;

  assign hdr12 = {6'b0, rec.hdr};
  assign adv = !feature_valid || feature_ready;
  assign load = !q_empty && (!busy || (adv && s_last));
  assign q_pop = load;

  always_comb begin
    step_next = cur;
    case (cur)
      efc_pkg::STEP_TIME: step_next = efc_pkg::STEP_SIZE;
      efc_pkg::STEP_SIZE: step_next = efc_pkg::STEP_SRC;
      efc_pkg::STEP_SRC: step_next = efc_pkg::STEP_DEST;
      efc_pkg::STEP_DEST: step_next = efc_pkg::STEP_HDR;
      efc_pkg::STEP_HDR:
        step_next = (rec.kind == efc_pkg::KIND_ETH) ? efc_pkg::STEP_ETYPE
                                                    : efc_pkg::STEP_LLC_HDR;
      efc_pkg::STEP_ETYPE: step_next = efc_pkg::STEP_NEST;
      efc_pkg::STEP_LLC_HDR: step_next = efc_pkg::STEP_LLC_SRC;
      efc_pkg::STEP_LLC_SRC: step_next = efc_pkg::STEP_LLC_DEST;
      efc_pkg::STEP_LLC_DEST: begin
        case (rec.kind)
          efc_pkg::KIND_SNAP: step_next = efc_pkg::STEP_SNAP;
          efc_pkg::KIND_DSAP: step_next = efc_pkg::STEP_DSAP;
          default: step_next = efc_pkg::STEP_LLC_UNK;
        endcase
      end
      efc_pkg::STEP_SNAP: step_next = efc_pkg::STEP_SNAP_ORG;
      efc_pkg::STEP_SNAP_ORG: step_next = efc_pkg::STEP_ETYPE;
      default: step_next = efc_pkg::STEP_TIME;
    endcase
  end

  always_comb begin
    s_code = efc_pkg::CODE_TIME;
    s_off = '0;
    s_len = '0;
    s_last = 1'b0;
    case (cur)
      efc_pkg::STEP_TIME: begin
        s_len = {6'b0, rec.time_len};
      end
      efc_pkg::STEP_SIZE: begin
        s_code = efc_pkg::CODE_SIZE;
        s_off = {7'b0, rec.time_len};
        s_len = {6'b0, rec.count_len};
        s_last = !rec.cap_nz;
      end
      efc_pkg::STEP_SRC: begin
        s_code = efc_pkg::CODE_ETH_SRC;
        s_off = hdr12 + 12'd6;
        s_len = 11'd6;
      end
      efc_pkg::STEP_DEST: begin
        s_code = efc_pkg::CODE_ETH_DEST;
        s_off = hdr12;
        s_len = 11'd6;
      end
      efc_pkg::STEP_HDR: begin
        s_code = efc_pkg::CODE_ETH_HDR;
        s_off = hdr12;
        s_len = 11'd12;
      end
      efc_pkg::STEP_ETYPE: begin
        s_code = efc_pkg::CODE_ETHERTYPE;
        s_off = rec.eoff;
        s_len = 11'd2;
        s_last = !rec.nest_valid;
      end
      efc_pkg::STEP_NEST: begin
        s_code = rec.nest_code;
        s_off = rec.eoff + 12'd2;
        s_len = rec.nest_len;
        s_last = 1'b1;
      end
      efc_pkg::STEP_LLC_HDR: begin
        s_code = efc_pkg::CODE_LLC_HDR;
        s_off = hdr12 + 12'd14;
        s_len = 11'd3;
      end
      efc_pkg::STEP_LLC_SRC: begin
        s_code = efc_pkg::CODE_LLC_SRC;
        s_off = hdr12 + 12'd14;
        s_len = 11'd1;
      end
      efc_pkg::STEP_LLC_DEST: begin
        s_code = efc_pkg::CODE_LLC_DEST;
        s_off = hdr12 + 12'd15;
        s_len = 11'd1;
      end
      efc_pkg::STEP_SNAP: begin
        s_code = efc_pkg::CODE_SNAP;
        s_off = hdr12 + 12'd17;
        s_len = 11'd5;
      end
      efc_pkg::STEP_SNAP_ORG: begin
        s_code = efc_pkg::CODE_SNAP_ORG;
        s_off = hdr12 + 12'd17;
        s_len = 11'd3;
      end
      efc_pkg::STEP_DSAP: begin
        s_code = efc_pkg::CODE_DSAP;
        s_off = hdr12 + 12'd17;
        s_len = rec.dsap_len;
        s_last = 1'b1;
      end
      efc_pkg::STEP_LLC_UNK: begin
        s_code = efc_pkg::CODE_LLC_UNKNOWN;
        s_off = hdr12 + 12'd14;
        s_len = 11'd3;
        s_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cur <= efc_pkg::STEP_TIME;
      feature_valid <= 1'b0;
    end else begin
      if (adv) feature_valid <= busy;
      if (load) begin
        busy <= 1'b1;
        cur <= efc_pkg::STEP_TIME;
      end else if (busy && adv) begin
        cur <= step_next;
        if (s_last) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) rec <= q_head;
    if (busy && adv) begin
      feature_code <= s_code;
      field_offset <= s_off;
      field_length <= s_len;
      last_feature <= s_last;
    end
  end

endmodule

// ----- rtl/core/ethernet_frame_classifier.sv -----
// ethernet frame classifier top: a byte per cycle in, a feature per cycle out, if not stalled
// a record's features pass queue, record register and output register; bursts of 2 to 12
// a queue of 4 records holds finished records; bytes stall only when a record ends with it full
// reset: position, header words, queue and output valid clear; registers load 4, 2 and 64
// depends on efc_pkg, efc_front, efc_queue, efc_back
module ethernet_frame_classifier #(
  parameter int MAX_CAPTURE = efc_pkg::MAX_CAPTURE_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic [1:0]   cfg_index,
  input  logic [10:0]  cfg_data,
  input  logic         byte_valid,
  output logic         byte_ready,
  input  logic [7:0]   data_byte,
  output logic         feature_valid,
  input  logic         feature_ready,
  output logic [4:0]   feature_code,
  output logic [11:0]  field_offset,
  output logic [10:0]  field_length,
  output logic         last_feature
);

  efc_pkg::queue_ctl_t q_req;
  efc_pkg::queue_ctl_t q_stat;
  efc_pkg::rec_t q_wr;
  efc_pkg::rec_t q_rd;
  logic push;
  logic pop;

  assign q_req.push = push;
  assign q_req.pop = pop;
  assign q_req.full = 1'b0;
  assign q_req.empty = 1'b0;

  efc_front #(
    .MAX_CAPTURE(MAX_CAPTURE)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .data_byte(data_byte),
    .q_full(q_stat.full),
    .q_push(push),
    .q_data(q_wr)
  );

  efc_queue u_queue (
    .clk(clk),
    .rst(rst),
    .ctl_in(q_req),
    .ctl_out(q_stat),
    .wr_data(q_wr),
    .rd_data(q_rd)
  );

  efc_back u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_stat.empty),
    .q_pop(pop),
    .q_head(q_rd),
    .feature_valid(feature_valid),
    .feature_ready(feature_ready),
    .feature_code(feature_code),
    .field_offset(field_offset),
    .field_length(field_length),
    .last_feature(last_feature)
  );

endmodule

// ----- rtl/core/efc_checker.sv -----
// port-level checks of the feature output of the frame classifier, bound to the top level
// depends on efc_pkg and ethernet_frame_classifier_assert.svh
`include "ethernet_frame_classifier_assert.svh"

module efc_checker (
  input logic         clk,
  input logic         rst,
  input logic         cfg_write,
  input logic [1:0]   cfg_index,
  input logic [10:0]  cfg_data,
  input logic         byte_valid,
  input logic         byte_ready,
  input logic [7:0]   data_byte,
  input logic         feature_valid,
  input logic         feature_ready,
  input logic [4:0]   feature_code,
  input logic [11:0]  field_offset,
  input logic [10:0]  field_length,
  input logic         last_feature
);

  logic burst_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_start <= 1'b1;
    end else if (feature_valid && feature_ready) begin
      burst_start <= last_feature;
    end
  end

  `EFC_ASSERT_NEXT(a_hold, clk, rst, feature_valid && !feature_ready, feature_valid && $stable(feature_code) && $stable(field_offset) && $stable(field_length) && $stable(last_feature), "stalled feature request changed")
  `EFC_ASSERT_IMPL(a_burst_head, clk, rst, feature_valid && burst_start, feature_code == efc_pkg::CODE_TIME && field_offset == 12'd0, "burst does not open with time")
  `EFC_ASSERT_IMPL(a_time_not_last, clk, rst, feature_valid && feature_code == efc_pkg::CODE_TIME, !last_feature, "time feature closes a burst")
  `EFC_ASSERT_IMPL(a_code_range, clk, rst, feature_valid, feature_code <= efc_pkg::CODE_LLC_UNKNOWN, "feature code out of range")

endmodule

bind ethernet_frame_classifier efc_checker u_efc_checker (.*);
